// ===== hw/rtl/lmfc_pkg.sv =====
// lmfc_pkg: shared types and constants of the lift motor fault controller
// no dependencies; imported by every rtl file of the block

package lmfc_pkg;

  // controller modes, also the mode_code output
  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_UP    = 2'd1,
    MODE_DOWN  = 2'd2,
    MODE_FAULT = 2'd3
  } mode_t;

  // motor drive codes; the fourth code is unused
  typedef enum logic [1:0] {
    CMD_STOP = 2'd0,
    CMD_UP   = 2'd1,
    CMD_DOWN = 2'd2
  } cmd_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_SENSE_EN    = 2'd0,
    REG_STUCK_THR   = 2'd1,
    REG_OBSTR_THR   = 2'd2,
    REG_FAULT_TIME  = 2'd3
  } reg_index_t;

  localparam int CFG_DATA_BITS = 16;

  localparam logic [15:0] STUCK_THR_RESET  = 16'd500;
  localparam logic [15:0] OBSTR_THR_RESET  = 16'd3000;
  localparam logic [15:0] FAULT_TIME_RESET = 16'd100;

  localparam logic [7:0] SPEED_FULL = 8'd255;
  localparam logic [7:0] SPEED_OFF  = 8'd0;

  typedef struct packed {
    logic        sense_en;
    logic [15:0] stuck_thr_ma;
    logic [15:0] obstr_thr_ma;
    logic [15:0] fault_time_ms;
  } cfg_t;

  typedef struct packed {
    cmd_t  cmd;
    logic  any_fault;
    mode_t mode;
  } result_t;

endpackage

// ===== hw/rtl/lmfc_cfg_regs.sv =====
// lmfc_cfg_regs: configuration register file of the fault controller
// depends on lmfc_pkg

module lmfc_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  lmfc_pkg::reg_index_t               wr_index,
  input  logic [lmfc_pkg::CFG_DATA_BITS-1:0] wr_data,
  output lmfc_pkg::cfg_t                     cfg
);
  import lmfc_pkg::*;

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.sense_en      <= 1'b0;
      regs.stuck_thr_ma  <= STUCK_THR_RESET;
      regs.obstr_thr_ma  <= OBSTR_THR_RESET;
      regs.fault_time_ms <= FAULT_TIME_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_SENSE_EN:   regs.sense_en      <= wr_data[0];
        REG_STUCK_THR:  regs.stuck_thr_ma  <= wr_data[15:0];
        REG_OBSTR_THR:  regs.obstr_thr_ma  <= wr_data[15:0];
        REG_FAULT_TIME: regs.fault_time_ms <= wr_data[15:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

// ===== hw/rtl/lmfc_core.sv =====
// lmfc_core: controller state and the per-sample step logic
// depends on lmfc_pkg; state advances once per sample when step is high

module lmfc_core #(
  parameter int TIME_BITS    = 32,
  parameter int CURRENT_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  logic                    up_pressed,
  input  logic                    down_pressed,
  input  logic                    ext_fault,
  input  logic                    upper_limit_hit,
  input  logic                    lower_limit_hit,
  input  logic [TIME_BITS-1:0]    now_ms,
  input  logic [CURRENT_BITS-1:0] current_ma,
  input  lmfc_pkg::cfg_t          cfg,
  output lmfc_pkg::result_t       res
);
  import lmfc_pkg::*;

  localparam int CMP_BITS = (CURRENT_BITS > 16) ? CURRENT_BITS : 16;

  mode_t                mode, mode_next;
  logic                 button_fault, button_fault_next;
  logic                 external_fault, external_fault_next;
  logic                 current_fault, current_fault_next;
  logic                 stuck_run, stuck_run_next;
  logic [TIME_BITS-1:0] stuck_start, stuck_start_next;
  logic                 obstr_run, obstr_run_next;
  logic [TIME_BITS-1:0] obstr_start, obstr_start_next;

  logic                 released;
  logic                 dual_limit;
  logic                 any_fault;
  cmd_t                 cmd;
  logic [CMP_BITS-1:0]  cur_ext;
  logic                 over_stuck, over_obstr;
  logic                 stuck_due, obstr_due;

  assign cur_ext    = CMP_BITS'(current_ma);
  assign over_stuck = cur_ext > CMP_BITS'(cfg.stuck_thr_ma);
  assign over_obstr = cur_ext > CMP_BITS'(cfg.obstr_thr_ma);
  // wrapping elapsed time against the persistence window
  assign stuck_due  = (now_ms - stuck_start) >= TIME_BITS'(cfg.fault_time_ms);
  assign obstr_due  = (now_ms - obstr_start) >= TIME_BITS'(cfg.fault_time_ms);
  assign released   = !up_pressed && !down_pressed;
  assign dual_limit = upper_limit_hit && lower_limit_hit;

  always_comb begin
    button_fault_next   = button_fault;
    external_fault_next = external_fault;
    current_fault_next  = current_fault;
    stuck_run_next      = stuck_run;
    stuck_start_next    = stuck_start;
    obstr_run_next      = obstr_run;
    obstr_start_next    = obstr_start;
    mode_next           = mode;
    cmd                 = CMD_STOP;

    // recovery, only from the fault mode
    if (mode == MODE_FAULT) begin
      if (released) button_fault_next = 1'b0;
      if (!ext_fault) external_fault_next = 1'b0;
      if (current_fault && released) begin
        current_fault_next = 1'b0;
        stuck_run_next     = 1'b0;
        obstr_run_next     = 1'b0;
      end
    end

    if (up_pressed && down_pressed) button_fault_next = 1'b1;
    if (ext_fault) external_fault_next = 1'b1;

    unique case (mode)
      MODE_UP: begin
        if (!up_pressed || upper_limit_hit) mode_next = MODE_IDLE;
        else cmd = CMD_UP;
      end
      MODE_DOWN: begin
        if (!down_pressed || lower_limit_hit) mode_next = MODE_IDLE;
        else cmd = CMD_DOWN;
      end
      MODE_FAULT: cmd = CMD_STOP;
      default: begin
        if (up_pressed && !upper_limit_hit) begin
          mode_next = MODE_UP;
          cmd       = CMD_UP;
        end else if (down_pressed && !lower_limit_hit) begin
          mode_next = MODE_DOWN;
          cmd       = CMD_DOWN;
        end
      end
    endcase

    // overcurrent watch, timer picked by this sample's drive
    if (cfg.sense_en) begin
      if (cmd == CMD_STOP) begin
        obstr_run_next = 1'b0;
        if (over_stuck) begin
          if (!stuck_run_next) begin
            stuck_run_next   = 1'b1;
            stuck_start_next = now_ms;
          end else if (stuck_due) begin
            current_fault_next = 1'b1;
          end
        end else begin
          stuck_run_next = 1'b0;
        end
      end else begin
        stuck_run_next = 1'b0;
        if (over_obstr) begin
          if (!obstr_run_next) begin
            obstr_run_next   = 1'b1;
            obstr_start_next = now_ms;
          end else if (obstr_due) begin
            current_fault_next = 1'b1;
          end
        end else begin
          obstr_run_next = 1'b0;
        end
      end
    end else begin
      stuck_run_next = 1'b0;
      obstr_run_next = 1'b0;
    end

    any_fault = button_fault_next || external_fault_next || current_fault_next || dual_limit;
    if (any_fault) begin
      mode_next = MODE_FAULT;
      cmd       = CMD_STOP;
    end else if (mode_next == MODE_FAULT) begin
      mode_next = MODE_IDLE;
      cmd       = CMD_STOP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_IDLE;
      button_fault   <= 1'b0;
      external_fault <= 1'b0;
      current_fault  <= 1'b0;
      stuck_run      <= 1'b0;
      stuck_start    <= '0;
      obstr_run      <= 1'b0;
      obstr_start    <= '0;
    end else if (step) begin
      mode           <= mode_next;
      button_fault   <= button_fault_next;
      external_fault <= external_fault_next;
      current_fault  <= current_fault_next;
      stuck_run      <= stuck_run_next;
      stuck_start    <= stuck_start_next;
      obstr_run      <= obstr_run_next;
      obstr_start    <= obstr_start_next;
    end
  end

  assign res.cmd       = cmd;
  assign res.any_fault = any_fault;
  assign res.mode      = mode_next;

`ifndef NO_ASSERTIONS
  a_one_timer: assert property (@(posedge clk) disable iff (rst)
    !(stuck_run && obstr_run))
    else $error("both current timers running");

  a_sense_off: assert property (@(posedge clk) disable iff (rst)
    (step && !cfg.sense_en) |=> (!stuck_run && !obstr_run))
    else $error("timer running with current sensing off");

  a_latch_mode: assert property (@(posedge clk) disable iff (rst)
    (button_fault || external_fault || current_fault) |-> (mode == MODE_FAULT))
    else $error("latched fault outside fault mode");

  a_fault_stops: assert property (@(posedge clk) disable iff (rst)
    res.any_fault |-> (res.cmd == CMD_STOP && res.mode == MODE_FAULT))
    else $error("motor driven while a fault is active");
`endif

endmodule

// ===== hw/rtl/lift_motor_fault_controller.sv =====
// lift_motor_fault_controller: top level with input and result registers
// depends on lmfc_pkg, lmfc_cfg_regs and lmfc_core
//
// usage
//   input channel : one control sample per request (buttons, limits, external
//                   fault, now_ms, current_ma), in_valid / in_stall
//   output channel: one result per sample (motor drive, leds, fault flag,
//                   mode after the sample), out_valid / out_stall
//   config channel: cfg_valid / cfg_ready, cfg_index selects the register,
//                   cfg_data carries the value; cfg_ready is always high
// path: a sample lands in the input register when it is accepted, and its
//   result is loaded into the result register, which drives out_valid, once
//   that register is empty or its result is being taken
// throughput: one sample per cycle unless out_stall blocks; the step logic
//   (compares, two wrapping subtracts) sits between input and result registers
// stall: while out_stall holds a result, one more sample may wait in the
//   input register; after that in_stall rises until the result is taken
// reset: rst (synchronous) empties both registers, returns to idle with all
//   fault latches and timers cleared, and loads the register defaults

module lift_motor_fault_controller #(
  parameter int TIME_BITS    = 32,
  parameter int CURRENT_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  // sample channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               up_pressed,
  input  logic                               down_pressed,
  input  logic                               ext_fault,
  input  logic                               upper_limit_hit,
  input  logic                               lower_limit_hit,
  input  logic [TIME_BITS-1:0]               now_ms,
  input  logic [CURRENT_BITS-1:0]            current_ma,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         motor_command,
  output logic [7:0]                         drive_speed,
  output logic                               up_led,
  output logic                               down_led,
  output logic                               error_led,
  output logic                               fault_flag,
  output logic [1:0]                         mode_code,
  // configuration channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  lmfc_pkg::reg_index_t               cfg_index,
  input  logic [lmfc_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import lmfc_pkg::*;

  // input register
  logic                    sample_valid;
  logic                    s_up, s_down, s_ext, s_ulim, s_llim;
  logic [TIME_BITS-1:0]    s_now;
  logic [CURRENT_BITS-1:0] s_cur;

  // result register
  logic                    result_valid;
  result_t                 result;

  cfg_t                    cfg;
  result_t                 step_res;
  logic                    out_ready;
  logic                    advance;
  logic                    in_accept;

  // result register can load when empty or being taken this cycle
  assign out_ready = !result_valid || !out_stall;
  assign advance   = sample_valid && out_ready;
  assign in_stall  = sample_valid && !out_ready;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  lmfc_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  lmfc_core #(
    .TIME_BITS    (TIME_BITS),
    .CURRENT_BITS (CURRENT_BITS)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .step            (advance),
    .up_pressed      (s_up),
    .down_pressed    (s_down),
    .ext_fault       (s_ext),
    .upper_limit_hit (s_ulim),
    .lower_limit_hit (s_llim),
    .now_ms          (s_now),
    .current_ma      (s_cur),
    .cfg             (cfg),
    .res             (step_res)
  );

  // sample register control
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (in_accept) begin
      sample_valid <= 1'b1;
    end else if (advance) begin
      sample_valid <= 1'b0;
    end
  end

  // sample payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s_up   <= up_pressed;
      s_down <= down_pressed;
      s_ext  <= ext_fault;
      s_ulim <= upper_limit_hit;
      s_llim <= lower_limit_hit;
      s_now  <= now_ms;
      s_cur  <= current_ma;
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (out_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= step_res;
    end
  end

  // outputs decoded from the held result
  assign out_valid     = result_valid;
  assign motor_command = result.cmd;
  assign drive_speed   = (result.cmd != CMD_STOP) ? SPEED_FULL : SPEED_OFF;
  assign up_led        = (result.cmd == CMD_UP);
  assign down_led      = (result.cmd == CMD_DOWN);
  assign error_led     = result.any_fault;
  assign fault_flag    = result.any_fault;
  assign mode_code     = result.mode;

`ifndef NO_ASSERTIONS
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (result_valid && out_stall && sample_valid))
    else $error("input stalled without a blocked result");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && !advance) |=> sample_valid)
    else $error("pending sample lost");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && out_stall) |=> (result_valid && $stable(result)))
    else $error("stalled result changed");
`endif

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: self-checking bench for the lift motor fault controller
// depends on lmfc_pkg and lift_motor_fault_controller; needs nothing else

module tb_top;
  import lmfc_pkg::*;

  localparam int DIR_ROWS       = 25;
  localparam int SENSE_FIRST    = 16;    // first directed row run with sensing on
  localparam int SETTING_COUNT  = 6;
  localparam int PHASE_ITEMS    = 100;   // random requests per setting
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
  localparam int TAIL_CYCLES    = 8;     // result register holds one result

  // one control sample as the sender drives it
  typedef struct packed {
    logic        up;
    logic        down;
    logic        ext;
    logic        lim_up;
    logic        lim_down;
    logic [31:0] now;
    logic [15:0] cur;
  } sample_t;

  // one result as it leaves the block
  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  speed;
    logic        up_led;
    logic        down_led;
    logic        err_led;
    logic        fault;
    mode_t       mode;
  } drive_t;

  // directed stimulus row; typed rows carry a hand-written result
  typedef struct packed {
    sample_t s;
    logic    typed;
    drive_t  want;
  } dir_row_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_COIN,
    STALL_TOGGLE,
    STALL_HEAVY
  } stall_style_t;

  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_UP,
    HOLD_DOWN,
    HOLD_BOTH
  } button_hold_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  sample_t     in_sample;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  motor_command;
  logic [7:0]  drive_speed;
  logic        up_led;
  logic        down_led;
  logic        error_led;
  logic        fault_flag;
  logic [1:0]  mode_code;
  logic        cfg_valid;
  logic        cfg_ready;
  reg_index_t  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  // shadow of the controller: configuration, mode, latches and timers
  cfg_t        shadow_cfg;
  mode_t       lift_mode;
  logic        latch_button;
  logic        latch_ext;
  logic        latch_current;
  logic        stuck_run;
  logic [31:0] stuck_t0;
  logic        obstr_run;
  logic [31:0] obstr_t0;

  drive_t      pending_drives[$];
  dir_row_t    dir_rows[DIR_ROWS];
  logic [15:0] setting_words[SETTING_COUNT][4];

  // random sample shaping
  button_hold_t hold_kind;
  int           hold_left;
  logic [31:0]  clock_ms;

  int mismatch_count;
  int requests_sent;
  int results_checked;
  int settings_applied;
  int idle_cycles;

  // 4 ns clock
  always #2 clk = ~clk;

  lift_motor_fault_controller u_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .up_pressed      (in_sample.up),
    .down_pressed    (in_sample.down),
    .ext_fault       (in_sample.ext),
    .upper_limit_hit (in_sample.lim_up),
    .lower_limit_hit (in_sample.lim_down),
    .now_ms          (in_sample.now),
    .current_ma      (in_sample.cur),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .motor_command   (motor_command),
    .drive_speed     (drive_speed),
    .up_led          (up_led),
    .down_led        (down_led),
    .error_led       (error_led),
    .fault_flag      (fault_flag),
    .mode_code       (mode_code),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // helpers for building samples and results
  // ---------------------------------------------------------------------------

  function automatic sample_t mk_sample(logic up, logic down, logic ext, logic lim_up,
                                        logic lim_down, logic [31:0] now,
                                        logic [15:0] cur);
    sample_t s;
    s = '{up, down, ext, lim_up, lim_down, now, cur};
    return s;
  endfunction

  // speed and leds follow from the drive, both fault outputs from the fault state
  function automatic drive_t mk_drive(cmd_t cmd, logic fault, mode_t mode);
    drive_t d;
    d.cmd      = cmd;
    d.speed    = (cmd != CMD_STOP) ? SPEED_FULL : SPEED_OFF;
    d.up_led   = (cmd == CMD_UP);
    d.down_led = (cmd == CMD_DOWN);
    d.err_led  = fault;
    d.fault    = fault;
    d.mode     = mode;
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // predictor: advances the shadow state by one sample, returns its result
  // ---------------------------------------------------------------------------

  function automatic drive_t lift_step(sample_t s);
    cmd_t        cmd;
    logic        released;
    logic        dual_limit;
    logic        any_fault;
    logic        run;
    logic [31:0] t0;
    logic [31:0] elapsed;
    logic [15:0] thr;

    // recovery only happens while already in fault, ahead of new latching
    if (lift_mode == MODE_FAULT) begin
      released = !s.up && !s.down;
      if (released)
        latch_button = 1'b0;
      if (!s.ext)
        latch_ext = 1'b0;
      if (latch_current && released) begin
        latch_current = 1'b0;
        stuck_run     = 1'b0;
        obstr_run     = 1'b0;
      end
    end

    if (s.up && s.down)
      latch_button = 1'b1;
    if (s.ext)
      latch_ext = 1'b1;
    dual_limit = s.lim_up && s.lim_down;

    cmd = CMD_STOP;
    case (lift_mode)
      MODE_UP: begin
        if (!s.up || s.lim_up)
          lift_mode = MODE_IDLE;
        else
          cmd = CMD_UP;
      end
      MODE_DOWN: begin
        if (!s.down || s.lim_down)
          lift_mode = MODE_IDLE;
        else
          cmd = CMD_DOWN;
      end
      MODE_FAULT: cmd = CMD_STOP;
      default: begin
        if (s.up && !s.lim_up) begin
          lift_mode = MODE_UP;
          cmd       = CMD_UP;
        end else if (s.down && !s.lim_down) begin
          lift_mode = MODE_DOWN;
          cmd       = CMD_DOWN;
        end
      end
    endcase

    // the drive of this sample picks the timer; the other one is dropped
    if (shadow_cfg.sense_en) begin
      if (cmd == CMD_STOP) begin
        obstr_run = 1'b0;
        run       = stuck_run;
        t0        = stuck_t0;
        thr       = shadow_cfg.stuck_thr_ma;
      end else begin
        stuck_run = 1'b0;
        run       = obstr_run;
        t0        = obstr_t0;
        thr       = shadow_cfg.obstr_thr_ma;
      end
      if (s.cur > thr) begin
        elapsed = s.now - t0;  // wraps modulo 2^32
        if (!run) begin
          run = 1'b1;
          t0  = s.now;
        end else if (elapsed >= {16'd0, shadow_cfg.fault_time_ms}) begin
          latch_current = 1'b1;
        end
      end else begin
        run = 1'b0;
      end
      if (cmd == CMD_STOP) begin
        stuck_run = run;
        stuck_t0  = t0;
      end else begin
        obstr_run = run;
        obstr_t0  = t0;
      end
    end else begin
      stuck_run = 1'b0;
      obstr_run = 1'b0;
    end

    any_fault = latch_button || latch_ext || latch_current || dual_limit;
    if (any_fault) begin
      lift_mode = MODE_FAULT;
      cmd       = CMD_STOP;
    end else if (lift_mode == MODE_FAULT) begin
      lift_mode = MODE_IDLE;
    end
    return mk_drive(cmd, any_fault, lift_mode);
  endfunction

  // ---------------------------------------------------------------------------
  // random sample source: held buttons, a creeping clock, currents near limits
  // ---------------------------------------------------------------------------

  function automatic logic [15:0] near_thr(logic [15:0] thr);
    int v;
    v = int'(thr) + int'($urandom_range(0, 2)) - 1;
    if (v < 0)
      v = 0;
    if (v > 65535)
      v = 65535;
    return v[15:0];
  endfunction

  function automatic sample_t next_sample();
    sample_t s;
    int      pick;

    // some plain noise: every field drawn over its full range
    if ($urandom_range(0, 99) < 15) begin
      s = mk_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), $urandom,
                    16'($urandom_range(0, 65535)));
      return s;
    end

    // buttons are held for a run of samples, like a person would
    if (hold_left == 0) begin
      pick = $urandom_range(0, 19);
      if (pick < 6)
        hold_kind = HOLD_NONE;
      else if (pick < 12)
        hold_kind = HOLD_UP;
      else if (pick < 18)
        hold_kind = HOLD_DOWN;
      else
        hold_kind = HOLD_BOTH;
      hold_left = $urandom_range(1, 15);
    end
    hold_left--;
    s.up       = (hold_kind == HOLD_UP) || (hold_kind == HOLD_BOTH);
    s.down     = (hold_kind == HOLD_DOWN) || (hold_kind == HOLD_BOTH);
    s.ext      = ($urandom_range(0, 39) == 0);
    s.lim_up   = ($urandom_range(0, 11) == 0);
    s.lim_down = ($urandom_range(0, 11) == 0);

    // time moves in steps of up to a third of the fault time plus two, with a rare big jump
    if ($urandom_range(0, 49) == 0)
      clock_ms += $urandom;
    else
      clock_ms += $urandom_range(0, shadow_cfg.fault_time_ms / 3 + 2);
    s.now = clock_ms;

    pick = $urandom_range(0, 9);
    if (pick < 3)
      s.cur = 16'($urandom_range(0, shadow_cfg.stuck_thr_ma));
    else if (pick < 5)
      s.cur = near_thr(shadow_cfg.stuck_thr_ma);
    else if (pick < 7)
      s.cur = near_thr(shadow_cfg.obstr_thr_ma);
    else if (pick < 9)
      s.cur = 16'($urandom_range(shadow_cfg.stuck_thr_ma, 65535));
    else
      s.cur = 16'($urandom_range(0, 65535));
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    $display("[%0t] %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s: got %0h, want %0h", name, got, want));
  endtask

  // each accepted result is matched against the oldest prediction
  always @(posedge clk) begin
    drive_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_drives.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: cmd %0d mode %0d",
                                  motor_command, mode_code));
      end else begin
        want = pending_drives.pop_front();
        check_field("motor_command", 32'(motor_command), 32'(want.cmd));
        check_field("drive_speed", 32'(drive_speed), 32'(want.speed));
        check_field("up_led", 32'(up_led), 32'(want.up_led));
        check_field("down_led", 32'(down_led), 32'(want.down_led));
        check_field("error_led", 32'(error_led), 32'(want.err_led));
        check_field("fault_flag", 32'(fault_flag), 32'(want.fault));
        check_field("mode_code", 32'(mode_code), 32'(want.mode));
        results_checked++;
      end
    end
  end

  // watchdog: any handshake on any channel counts as progress
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: no handshake for %0d cycles", $time, idle_cycles);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: each stall style holds for a randomly drawn number of cycles
  // ---------------------------------------------------------------------------

  stall_style_t stall_style = STALL_NONE;
  int           stall_left  = 0;

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_style = stall_style_t'($urandom_range(0, 3));
      stall_left  = $urandom_range(10, 60);
    end
    stall_left--;
    case (stall_style)
      STALL_COIN:   out_stall <= 1'($urandom_range(0, 1));
      STALL_TOGGLE: out_stall <= ~out_stall;
      STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
      default:      out_stall <= 1'b0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // present one request and hold it until taken; typed rows bring their own answer
  task automatic send_sample(input sample_t s, input logic typed, input drive_t typed_drive);
    drive_t predicted;
    @(negedge clk);
    in_valid  = 1'b1;
    in_sample = s;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    predicted = lift_step(s);
    pending_drives.push_back(typed ? typed_drive : predicted);
    requests_sent++;
  endtask

  // stop sending and let every pending result come out
  task automatic wait_results_done();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_drives.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    case (idx)
      REG_SENSE_EN:   shadow_cfg.sense_en      = data[0];
      REG_STUCK_THR:  shadow_cfg.stuck_thr_ma  = data;
      REG_OBSTR_THR:  shadow_cfg.obstr_thr_ma  = data;
      REG_FAULT_TIME: shadow_cfg.fault_time_ms = data;
      default: ;
    endcase
  endtask

  // all four registers back to back, valid held high through the run
  task automatic apply_setting(input int k);
    write_reg(REG_SENSE_EN, setting_words[k][0]);
    write_reg(REG_STUCK_THR, setting_words[k][1]);
    write_reg(REG_OBSTR_THR, setting_words[k][2]);
    write_reg(REG_FAULT_TIME, setting_words[k][3]);
    @(negedge clk);
    cfg_valid = 1'b0;
    settings_applied++;
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int     burst_left;
    int     gap;
    drive_t no_drive;

    rst       = 1'b1;
    in_valid  = 1'b0;
    in_sample = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_SENSE_EN;
    cfg_data  = '0;
    no_drive  = '0;

    // shadow state as after reset
    shadow_cfg.sense_en      = 1'b0;
    shadow_cfg.stuck_thr_ma  = STUCK_THR_RESET;
    shadow_cfg.obstr_thr_ma  = OBSTR_THR_RESET;
    shadow_cfg.fault_time_ms = FAULT_TIME_RESET;
    lift_mode     = MODE_IDLE;
    latch_button  = 1'b0;
    latch_ext     = 1'b0;
    latch_current = 1'b0;
    stuck_run     = 1'b0;
    stuck_t0      = '0;
    obstr_run     = 1'b0;
    obstr_t0      = '0;
    hold_kind     = HOLD_NONE;
    hold_left     = 0;
    clock_ms      = '0;
    mismatch_count   = 0;
    requests_sent    = 0;
    results_checked  = 0;
    settings_applied = 0;
    idle_cycles      = 0;

    // register settings: sense word, stuck, obstruction, fault time
    // sense words with upper bits set check that only bit 0 counts
    setting_words[0] = '{16'h0001, 16'd1000, 16'd2000, 16'd10};
    setting_words[1] = '{16'hFFFF, 16'd300, 16'd1500, 16'd50};
    setting_words[2] = '{16'h0001, 16'd0, 16'd0, 16'd0};
    setting_words[3] = '{16'h0001, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    setting_words[4] = '{16'hFFFE, 16'd200, 16'd800, 16'd20};
    setting_words[5] = '{16'h0001, 16'd1200, 16'd2500, 16'd5};

    // directed rows at reset settings (sensing off), results typed in
    dir_rows[0]  = '{mk_sample(0, 0, 0, 0, 0, 32'd0, 16'd0), 1'b1,
                     mk_drive(CMD_STOP, 1'b0, MODE_IDLE)};
    dir_rows[1]  = '{mk_sample(1, 0, 0, 0, 0, 32'd1, 16'd0), 1'b1,
                     mk_drive(CMD_UP, 1'b0, MODE_UP)};
    // upper limit stops the climb
    dir_rows[2]  = '{mk_sample(1, 0, 0, 1, 0, 32'd2, 16'd0), 1'b1,
                     mk_drive(CMD_STOP, 1'b0, MODE_IDLE)};
    dir_rows[3]  = '{mk_sample(0, 1, 0, 0, 0, 32'd3, 16'd0), 1'b1,
                     mk_drive(CMD_DOWN, 1'b0, MODE_DOWN)};
    dir_rows[4]  = '{mk_sample(0, 1, 0, 0, 1, 32'd4, 16'd0), 1'b1,
                     mk_drive(CMD_STOP, 1'b0, MODE_IDLE)};
    // both buttons latch a fault that holds until both are released
    dir_rows[5]  = '{mk_sample(1, 1, 0, 0, 0, 32'd5, 16'd0), 1'b1,
                     mk_drive(CMD_STOP, 1'b1, MODE_FAULT)};
    dir_rows[6]  = '{mk_sample(1, 1, 0, 0, 0, 32'd6, 16'd0), 1'b1,
                     mk_drive(CMD_STOP, 1'b1, MODE_FAULT)};
    dir_rows[7]  = '{mk_sample(0, 0, 0, 0, 0, 32'd7, 16'd0), 1'b1,
                     mk_drive(CMD_STOP, 1'b0, MODE_IDLE)};
    // external fault, cleared only when the input drops
    dir_rows[8]  = '{mk_sample(0, 0, 1, 0, 0, 32'd8, 16'd0), 1'b1,
                     mk_drive(CMD_STOP, 1'b1, MODE_FAULT)};
    dir_rows[9]  = '{mk_sample(1, 0, 1, 0, 0, 32'd9, 16'd0), 1'b1,
                     mk_drive(CMD_STOP, 1'b1, MODE_FAULT)};
    // leaving fault goes to idle even with a button held
    dir_rows[10] = '{mk_sample(1, 0, 0, 0, 0, 32'd10, 16'd0), 1'b1,
                     mk_drive(CMD_STOP, 1'b0, MODE_IDLE)};
    // both limits at once is a transient fault
    dir_rows[11] = '{mk_sample(0, 0, 0, 1, 1, 32'd11, 16'd0), 1'b1,
                     mk_drive(CMD_STOP, 1'b1, MODE_FAULT)};
    dir_rows[12] = '{mk_sample(0, 0, 0, 0, 0, 32'd12, 16'd0), 1'b1,
                     mk_drive(CMD_STOP, 1'b0, MODE_IDLE)};
    // top of the time and current fields, current ignored while sensing is off
    dir_rows[13] = '{mk_sample(1, 0, 0, 0, 1, 32'hFFFF_FFFF, 16'hFFFF), 1'b1,
                     mk_drive(CMD_UP, 1'b0, MODE_UP)};
    dir_rows[14] = '{mk_sample(0, 0, 0, 0, 0, 32'd0, 16'hFFFF), 1'b1,
                     mk_drive(CMD_STOP, 1'b0, MODE_IDLE)};
    dir_rows[15] = '{mk_sample(0, 0, 0, 0, 0, 32'd1, 16'd0), 1'b1,
                     mk_drive(CMD_STOP, 1'b0, MODE_IDLE)};
    // sensing on from here: stuck timer across the clock wrap
    dir_rows[16] = '{mk_sample(0, 0, 0, 0, 0, 32'hFFFF_FFF8, 16'd1001), 1'b0, no_drive};
    dir_rows[17] = '{mk_sample(0, 0, 0, 0, 0, 32'd2, 16'd1001), 1'b0, no_drive};
    // current fault stays while a button is held
    dir_rows[18] = '{mk_sample(1, 0, 0, 0, 0, 32'd10, 16'd0), 1'b0, no_drive};
    dir_rows[19] = '{mk_sample(0, 0, 0, 0, 0, 32'd20, 16'd0), 1'b0, no_drive};
    // obstruction while moving up
    dir_rows[20] = '{mk_sample(1, 0, 0, 0, 0, 32'd100, 16'd2001), 1'b0, no_drive};
    dir_rows[21] = '{mk_sample(1, 0, 0, 0, 0, 32'd110, 16'd2001), 1'b0, no_drive};
    dir_rows[22] = '{mk_sample(0, 0, 0, 0, 0, 32'd120, 16'd0), 1'b0, no_drive};
    // current exactly at the threshold does not count
    dir_rows[23] = '{mk_sample(0, 0, 0, 0, 0, 32'd200, 16'd1000), 1'b0, no_drive};
    dir_rows[24] = '{mk_sample(0, 0, 0, 0, 0, 32'd205, 16'd1001), 1'b0, no_drive};

    // reset, released on a falling edge
    repeat (4)
      @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (i == SENSE_FIRST) begin
        wait_results_done();
        apply_setting(0);
      end
      send_sample(dir_rows[i].s, dir_rows[i].typed, dir_rows[i].want);
    end

    // random part: one phase per remaining register setting
    for (int k = 1; k < SETTING_COUNT; k++) begin
      wait_results_done();
      apply_setting(k);
      // first phase starts just short of the clock wrap
      clock_ms   = (k == 1) ? 32'hFFFF_F000 : $urandom;
      burst_left = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // halfway through each phase the sender waits for a full drain
        if (n == PHASE_ITEMS / 2)
          wait_results_done();
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 30);
          gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          if (gap != 0) begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1)
              @(negedge clk);
          end
        end
        burst_left--;
        send_sample(next_sample(), 1'b0, no_drive);
      end
    end

    // drain, then give the output register time to show anything stray
    wait_results_done();
    repeat (TAIL_CYCLES)
      @(posedge clk);

    $display("covered %0d requests (%0d directed) over %0d register settings",
             requests_sent, DIR_ROWS, settings_applied + 1);
    $display("compared %0d results with the predictor, %0d mismatching fields",
             results_checked, mismatch_count);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
